@@ rtl/core/sdi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types, constants and helpers of the spring damper integrator.
// ----------------------------------------------------------------------------
package sdi_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PREC_W = 31;
   localparam int unsigned DT_W   = 16;
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned OP_W   = DATA_W + 1;
   localparam int unsigned PROD_W = 2 * OP_W;
   localparam int unsigned SH_W   = PROD_W - FRAC_W;
   localparam int unsigned WIDE_W = SH_W + 1;

   localparam logic [DATA_W-1:0] STIFFNESS_RST    = 32'd11141120;
   localparam logic [DATA_W-1:0] DAMPING_RST      = 32'd1703936;
   localparam logic [DATA_W-1:0] INVERSE_MASS_RST = 32'd65536;
   localparam logic [PREC_W-1:0] PRECISION_RST    = 31'd655;

   localparam logic [1:0] REG_STIFFNESS    = 2'd0;
   localparam logic [1:0] REG_DAMPING      = 2'd1;
   localparam logic [1:0] REG_INVERSE_MASS = 2'd2;
   localparam logic [1:0] REG_PRECISION    = 2'd3;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_TARGET = 2'd1,
      CMD_SET_POS    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] stiffness;
      logic [DATA_W-1:0] damping;
      logic [DATA_W-1:0] inverse_mass;
      logic [PREC_W-1:0] precision;
   } cfg_type;

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'(33'sh0_7FFF_FFFF));
      lo = WIDE_W'(signed'(33'sh1_8000_0000));
      if (x > hi) begin
         sat_q = 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         sat_q = 32'sh8000_0000;
      end else begin
         sat_q = x[DATA_W-1:0];
      end
   endfunction

endpackage

@@ rtl/core/sdi_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sdi_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sdi_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [sdi_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [sdi_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready,
   output sdi_pkg::cfg_type                cfg
);

   sdi_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[sdi_pkg::ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stiffness    <= sdi_pkg::STIFFNESS_RST;
         cfg_ff.damping      <= sdi_pkg::DAMPING_RST;
         cfg_ff.inverse_mass <= sdi_pkg::INVERSE_MASS_RST;
         cfg_ff.precision    <= sdi_pkg::PRECISION_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            sdi_pkg::REG_STIFFNESS:    cfg_ff.stiffness    <= csr_pwdata;
            sdi_pkg::REG_DAMPING:      cfg_ff.damping      <= csr_pwdata;
            sdi_pkg::REG_INVERSE_MASS: cfg_ff.inverse_mass <= csr_pwdata;
            sdi_pkg::REG_PRECISION:
               cfg_ff.precision <= csr_pwdata[sdi_pkg::PREC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         sdi_pkg::REG_STIFFNESS:    csr_prdata = cfg_ff.stiffness;
         sdi_pkg::REG_DAMPING:      csr_prdata = cfg_ff.damping;
         sdi_pkg::REG_INVERSE_MASS: csr_prdata = cfg_ff.inverse_mass;
         sdi_pkg::REG_PRECISION:    csr_prdata = {1'b0, cfg_ff.precision};
         default:                   csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/core/sdi_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sdi_mul (
   input  logic                                clock,
   input  logic signed [sdi_pkg::OP_W-1:0]     op_a,
   input  logic signed [sdi_pkg::OP_W-1:0]     op_b,
   output logic signed [sdi_pkg::PROD_W-1:0]   prod
);

   logic signed [sdi_pkg::PROD_W-1:0] prod_ff;
   logic signed [sdi_pkg::PROD_W-1:0] prod_in;

   assign prod_in = sdi_pkg::PROD_W'(op_a) * sdi_pkg::PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/core/sdi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_ctrl
// Command sequencer, spring state and result register; drives the shared
// multiplier one product at a time.
// ----------------------------------------------------------------------------
module sdi_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  sdi_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic signed [sdi_pkg::DATA_W-1:0]   req_value,
   input  logic [sdi_pkg::DT_W-1:0]            req_dt,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sdi_pkg::DATA_W-1:0]   rsp_position,
   output logic signed [sdi_pkg::DATA_W-1:0]   rsp_velocity,
   output logic                                rsp_at_rest,
   output logic signed [sdi_pkg::OP_W-1:0]     mul_a,
   output logic signed [sdi_pkg::OP_W-1:0]     mul_b,
   input  logic signed [sdi_pkg::PROD_W-1:0]   mul_prod
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0_0000_0000_0001,
      ST_DIST  = 13'b0_0000_0000_0010,
      ST_M_SPR = 13'b0_0000_0000_0100,
      ST_M_DMP = 13'b0_0000_0000_1000,
      ST_SUM   = 13'b0_0000_0001_0000,
      ST_M_ACC = 13'b0_0000_0010_0000,
      ST_ACC   = 13'b0_0000_0100_0000,
      ST_M_VEL = 13'b0_0000_1000_0000,
      ST_UPD_V = 13'b0_0001_0000_0000,
      ST_M_POS = 13'b0_0010_0000_0000,
      ST_UPD_P = 13'b0_0100_0000_0000,
      ST_REST  = 13'b0_1000_0000_0000,
      ST_DONE  = 13'b1_0000_0000_0000
   } state_type;

   localparam int unsigned DW = sdi_pkg::DATA_W;
   localparam int unsigned WW = sdi_pkg::WIDE_W;
   localparam int unsigned OW = sdi_pkg::OP_W;

   state_type             state_ff, state_in;
   logic signed [DW-1:0]  pos_ff, vel_ff, target_ff;
   logic                  resting_ff;
   logic signed [DW-1:0]  dist_ff;
   logic signed [DW-1:0]  acc_ff;
   logic [sdi_pkg::DT_W-1:0] dt_ff;
   logic                  rsp_valid_ff;
   logic signed [DW-1:0]  rsp_pos_ff, rsp_vel_ff;
   logic                  rsp_rest_ff;

   logic                  accept;
   logic                  out_free;
   logic signed [sdi_pkg::SH_W-1:0] prod_sh;
   logic signed [WW-1:0]  prod_wide;
   logic signed [DW-1:0]  prod_q;
   logic signed [DW:0]    exact_dist;
   logic [DW:0]           dist_mag;
   logic [DW:0]           vel_mag;
   logic [DW:0]           prec_ext;
   logic                  settle;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid & req_ready;
   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_velocity = rsp_vel_ff;
   assign rsp_at_rest  = rsp_rest_ff;

   // Dropping the 16 fraction bits of a signed product is a floor.
   assign prod_sh   = mul_prod[sdi_pkg::PROD_W-1:sdi_pkg::FRAC_W];
   assign prod_wide = {prod_sh[sdi_pkg::SH_W-1], prod_sh};
   assign prod_q    = sdi_pkg::sat_q(prod_wide);

   // The rest test looks at the exact distance, not the saturated one.
   assign exact_dist = {pos_ff[DW-1], pos_ff} - {target_ff[DW-1], target_ff};
   assign dist_mag   = exact_dist[DW] ? (DW+1)'(-exact_dist) : exact_dist;
   assign vel_mag    = vel_ff[DW-1] ? (DW+1)'(-{vel_ff[DW-1], vel_ff})
                                    : {1'b0, vel_ff};
   assign prec_ext   = {2'b00, cfg.precision};
   assign settle     = (vel_mag < prec_ext) && (dist_mag < prec_ext);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_M_SPR: begin
            mul_a = {1'b0, cfg.stiffness};
            mul_b = -{dist_ff[DW-1], dist_ff};
         end
         ST_M_DMP: begin
            mul_a = {1'b0, cfg.damping};
            mul_b = -{vel_ff[DW-1], vel_ff};
         end
         ST_M_ACC: begin
            mul_a = {acc_ff[DW-1], acc_ff};
            mul_b = {1'b0, cfg.inverse_mass};
         end
         ST_M_VEL: begin
            mul_a = {acc_ff[DW-1], acc_ff};
            mul_b = {(OW - sdi_pkg::DT_W)'(0), dt_ff};
         end
         ST_M_POS: begin
            mul_a = {vel_ff[DW-1], vel_ff};
            mul_b = {(OW - sdi_pkg::DT_W)'(0), dt_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_cmd == sdi_pkg::CMD_TICK) && !resting_ff) begin
                  state_in = ST_DIST;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIST:  state_in = ST_M_SPR;
         ST_M_SPR: state_in = ST_M_DMP;
         ST_M_DMP: state_in = ST_SUM;
         ST_SUM:   state_in = ST_M_ACC;
         ST_M_ACC: state_in = ST_ACC;
         ST_ACC:   state_in = ST_M_VEL;
         ST_M_VEL: state_in = ST_UPD_V;
         ST_UPD_V: state_in = ST_M_POS;
         ST_M_POS: state_in = ST_UPD_P;
         ST_UPD_P: state_in = ST_REST;
         ST_REST:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         target_ff    <= '0;
         resting_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_cmd == sdi_pkg::CMD_SET_TARGET) begin
                     target_ff  <= req_value;
                     resting_ff <= 1'b0;
                  end else if (req_cmd == sdi_pkg::CMD_SET_POS) begin
                     pos_ff <= req_value;
                  end
               end
            end
            ST_UPD_V: vel_ff <= sdi_pkg::sat_q(WW'(vel_ff) + prod_wide);
            ST_UPD_P: pos_ff <= sdi_pkg::sat_q(WW'(pos_ff) + prod_wide);
            ST_REST: begin
               if (settle) begin
                  pos_ff     <= target_ff;
                  vel_ff     <= '0;
                  resting_ff <= 1'b1;
               end
            end
            default: ;
         endcase

         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the result beat carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         dt_ff <= req_dt;
      end
      if (state_ff == ST_DIST) begin
         dist_ff <= sdi_pkg::sat_q(WW'(exact_dist));
      end
      if ((state_ff == ST_M_DMP) || (state_ff == ST_ACC)) begin
         acc_ff <= prod_q;
      end else if (state_ff == ST_SUM) begin
         acc_ff <= sdi_pkg::sat_q(WW'(acc_ff) + WW'(prod_q));
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_pos_ff  <= pos_ff;
         rsp_vel_ff  <= vel_ff;
         rsp_rest_ff <= resting_ff;
      end
   end

endmodule

@@ rtl/core/spring_damper_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damper_integrator
// Damped spring with semi-implicit Euler steps in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each request beat is one command and yields exactly one response beat with
// the position, velocity and rest flag after it. A set-target or set-position
// command, an unused command or a tick while the spring rests goes from idle
// straight to the done state, which loads the response register and makes
// the request side ready again once that register is free. An active tick
// first steps through the distance, product, sum, update and rest states;
// its five products all pass one shared 33 x 33 bit multiplier with a
// registered output. The request side is ready only while the sequencer is
// idle; a finished result may wait in the response register while the next
// command is accepted, and the next result then waits until that beat has
// been taken. Configuration registers are to be written through the CSR port
// only while no command is in flight; the block itself does not enforce this.
module spring_damper_integrator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic signed [sdi_pkg::DATA_W-1:0]   req_value,
   input  logic [sdi_pkg::DT_W-1:0]            req_dt,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sdi_pkg::DATA_W-1:0]   rsp_position,
   output logic signed [sdi_pkg::DATA_W-1:0]   rsp_velocity,
   output logic                                rsp_at_rest,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdi_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [sdi_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [sdi_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   sdi_pkg::cfg_type                   cfg;
   logic signed [sdi_pkg::OP_W-1:0]    mul_a;
   logic signed [sdi_pkg::OP_W-1:0]    mul_b;
   logic signed [sdi_pkg::PROD_W-1:0]  mul_prod;

   sdi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdi_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   sdi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .req_dt       (req_dt),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_velocity (rsp_velocity),
      .rsp_at_rest  (rsp_at_rest),
      .mul_a        (mul_a),
      .mul_b        (mul_b),
      .mul_prod     (mul_prod)
   );

endmodule

@@ rtl/core/sdi_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_chk
// Port-level checks of the spring damper integrator, bound to the top level.
// ----------------------------------------------------------------------------
module sdi_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [sdi_pkg::DATA_W-1:0]   rsp_position,
   input logic signed [sdi_pkg::DATA_W-1:0]   rsp_velocity,
   input logic                                rsp_at_rest
);

   // No response beat may be pending straight after reset.
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_velocity) && $stable(rsp_at_rest))
      else $error("stalled response changed");

   // One command at a time: the cycle after acceptance is never ready.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command accepted while busy");

   // A settled spring has no velocity.
   a_rest_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_rest |-> rsp_velocity == '0)
      else $error("at rest with non-zero velocity");

endmodule

bind spring_damper_integrator sdi_chk u_sdi_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_position (rsp_position),
   .rsp_velocity (rsp_velocity),
   .rsp_at_rest  (rsp_at_rest)
);
